>>> hdl/occupancy_grid_ray_update_core_macros.svh
// assertion helpers
`ifndef OCCUPANCY_GRID_RAY_UPDATE_CORE_MACROS_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_CORE_MACROS_SVH

`define OGRU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define OGRU_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hdl/ogru_pkg.sv
package ogru_pkg;

    localparam int GRID_SIZE = 256;
    localparam int CW = $clog2(GRID_SIZE);
    localparam int AW = 2 * CW;
    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int QD = 2;
    localparam int QW = $clog2(QD);

    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_FREE = 2'd1;
    localparam logic [1:0] ST_OCC = 2'd2;

    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_COUNTED = 2'd1;
    localparam logic [1:0] RES_NEW_OCC = 2'd2;
    localparam logic [1:0] RES_OLD_OCC = 2'd3;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_SCALE = 2'd1;
    localparam logic [1:0] REG_HALFWIDTH = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ = 1'b1;

    // classified command handed from front to back
    typedef struct packed {
        logic             is_read;
        logic             in_grid;
        logic             rover_in;
        logic [CW-1:0]    hx;
        logic [CW-1:0]    hy;
        logic [CW-1:0]    rx;
        logic [CW-1:0]    ry;
    } cmd_t;

endpackage

>>> hdl/ogru_front.sv
module ogru_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    opcode,
    input  logic signed [23:0]      hit_x,
    input  logic signed [23:0]      hit_y,
    input  logic signed [23:0]      rover_x,
    input  logic signed [23:0]      rover_y,
    input  logic [7:0]              read_col,
    input  logic [7:0]              read_row,
    input  logic [15:0]             scale,
    input  logic                    q_full,
    output logic                    busy,
    output logic                    push,
    output ogru_pkg::cmd_t          push_cmd
);

    // four coordinates scaled one per cycle by a single multiplier
    logic                   act_reg, act_next;
    logic [1:0]             idx_reg, idx_next;
    logic                   rd_reg, rd_next;
    logic [23:0]            coord_reg [4];
    logic [7:0]             rc_reg, rr_reg;
    logic signed [25:0]     cell_reg [4];
    logic                   done_reg, done_next;

    logic [23:0]            raw;
    logic                   neg;
    logic [23:0]            mag;
    logic [39:0]            prod;
    logic [23:0]            q;
    logic signed [25:0]     sc;

    assign raw  = coord_reg[idx_reg];
    assign neg  = raw[23];
    assign mag  = neg ? (24'd0 - raw) : raw;
    assign prod = mag * scale;
    assign q    = prod[39:16];
    assign sc   = (neg ? -$signed({2'b00, q}) : $signed({2'b00, q}))
                  + 26'(ogru_pkg::GRID_SIZE / 2);

    assign busy = act_reg || done_reg;

    always_comb
    begin
        act_next  = act_reg;
        idx_next  = idx_reg;
        rd_next   = rd_reg;
        done_next = done_reg;
        if (!busy && start)
        begin
            act_next = (opcode == ogru_pkg::OP_INSERT);
            done_next = (opcode == ogru_pkg::OP_READ);
            rd_next = (opcode == ogru_pkg::OP_READ);
            idx_next = 2'd0;
        end
        else if (act_reg)
        begin
            idx_next = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
            begin
                act_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg && !q_full)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            idx_reg  <= 2'd0;
            rd_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            act_reg  <= act_next;
            idx_reg  <= idx_next;
            rd_reg   <= rd_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy && start)
        begin
            coord_reg[0] <= hit_x;
            coord_reg[1] <= hit_y;
            coord_reg[2] <= rover_x;
            coord_reg[3] <= rover_y;
            rc_reg <= read_col;
            rr_reg <= read_row;
        end
        if (act_reg)
        begin
            cell_reg[idx_reg] <= sc;
        end
    end

    function automatic logic in_range(input logic signed [25:0] v);
        in_range = (v >= 0) && (v < 26'(ogru_pkg::GRID_SIZE));
    endfunction

    assign push = done_reg && !q_full;

    always_comb
    begin
        push_cmd.is_read  = rd_reg;
        if (rd_reg)
        begin
            push_cmd.in_grid  = 1'b1;
            push_cmd.rover_in = 1'b0;
            push_cmd.hx = ogru_pkg::CW'(rc_reg);
            push_cmd.hy = ogru_pkg::CW'(rr_reg);
        end
        else
        begin
            push_cmd.in_grid  = in_range(cell_reg[0]) && in_range(cell_reg[1]);
            push_cmd.rover_in = in_range(cell_reg[2]) && in_range(cell_reg[3]);
            push_cmd.hx = cell_reg[0][ogru_pkg::CW-1:0];
            push_cmd.hy = cell_reg[1][ogru_pkg::CW-1:0];
        end
        push_cmd.rx = cell_reg[2][ogru_pkg::CW-1:0];
        push_cmd.ry = cell_reg[3][ogru_pkg::CW-1:0];
    end

endmodule

>>> hdl/ogru_queue.sv
`include "occupancy_grid_ray_update_core_macros.svh"

module ogru_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ogru_pkg::cmd_t          push_cmd,
    input  logic                    pop,
    output logic                    full,
    output logic                    empty,
    output ogru_pkg::cmd_t          head
);

    ogru_pkg::cmd_t                 mem_reg [ogru_pkg::QD];
    logic [ogru_pkg::QW-1:0]        wp_reg, wp_next, rp_reg, rp_next;
    logic [ogru_pkg::QW:0]          cnt_reg, cnt_next;

    assign full  = (cnt_reg == (ogru_pkg::QW+1)'(ogru_pkg::QD));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg + ogru_pkg::QW'(push);
        rp_next  = rp_reg + ogru_pkg::QW'(pop);
        cnt_next = cnt_reg + (ogru_pkg::QW+1)'(push) - (ogru_pkg::QW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_cmd;
        end
    end

    `OGRU_ASSERT_NEVER(a_no_overflow, push && full, "queue overflow")
    `OGRU_ASSERT_NEVER(a_no_underflow, pop && empty, "queue underflow")
    `OGRU_ASSERT(a_count_bound, cnt_reg <= (ogru_pkg::QW+1)'(ogru_pkg::QD), "count out of range")

endmodule

>>> hdl/ogru_back.sv
`include "occupancy_grid_ray_update_core_macros.svh"

module ogru_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    empty,
    input  ogru_pkg::cmd_t          head,
    input  logic [7:0]              threshold,
    input  logic [1:0]              halfwidth,
    output logic                    pop,
    output logic                    idle,
    output logic                    done,
    output logic [1:0]              status,
    output logic [15:0]             freed_cells,
    output logic [1:0]              cell_state,
    output logic [7:0]              cell_hits
);

    localparam int CW = ogru_pkg::CW;
    localparam int AW = ogru_pkg::AW;
    localparam int EW = CW + 3;

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_RD     = 15'b000000000000100,
        S_UPD    = 15'b000000000001000,
        S_CSTART = 15'b000000000010000,
        S_CRD    = 15'b000000000100000,
        S_CCHK   = 15'b000000001000000,
        S_NSTART = 15'b000000010000000,
        S_NRD    = 15'b000000100000000,
        S_NCHK   = 15'b000001000000000,
        S_BSTART = 15'b000010000000000,
        S_BRD    = 15'b000100000000000,
        S_BCHK   = 15'b001000000000000,
        S_NNEXT  = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // cell memories, one read and one write port each
    logic [1:0]     occ_mem [ogru_pkg::DEPTH];
    logic [7:0]     hit_mem [ogru_pkg::DEPTH];
    logic [AW-1:0]  raddr, waddr;
    logic           occ_we, hit_we;
    logic [1:0]     occ_wd;
    logic [7:0]     hit_wd;
    logic [1:0]     occ_q;
    logic [7:0]     hit_q;

    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[waddr] <= occ_wd;
        end
        if (hit_we)
        begin
            hit_mem[waddr] <= hit_wd;
        end
        occ_q <= occ_mem[raddr];
        hit_q <= hit_mem[raddr];
    end

    ogru_pkg::cmd_t     cmd_reg;
    logic [AW:0]        clr_reg, clr_next;
    logic [16:0]        cnt_reg, cnt_next;
    logic [1:0]         st_reg, st_next;
    logic [1:0]         cs_reg, cs_next;
    logic [7:0]         ch_reg, ch_next;

    // core walk
    logic signed [EW-1:0] cx_reg, cx_next, cy_reg, cy_next, ce_reg, ce_next;
    logic [CW-1:0]        dx, dy;
    logic                 sxp, syp;
    // neighbour offsets
    logic signed [3:0]    ox_reg, ox_next, oy_reg, oy_next;
    logic signed [EW-1:0] nx, ny;
    // line of sight walk
    logic signed [EW-1:0] bx_reg, bx_next, by_reg, by_next, be_reg, be_next;
    logic signed [EW-1:0] bdx_reg, bdx_next, bdy_reg, bdy_next;
    logic                 bsx_reg, bsx_next, bsy_reg, bsy_next;
    logic signed [EW-1:0] tdx, tdy;

    logic signed [EW-1:0] hxs, hys, rxs, rys, r;
    logic                 over, right;

    assign hxs = EW'(cmd_reg.hx);
    assign hys = EW'(cmd_reg.hy);
    assign rxs = EW'(cmd_reg.rx);
    assign rys = EW'(cmd_reg.ry);
    assign r   = EW'(halfwidth);
    assign over  = cmd_reg.hy < cmd_reg.ry;
    assign right = cmd_reg.hx > cmd_reg.rx;
    assign dx  = right ? cmd_reg.hx - cmd_reg.rx : cmd_reg.rx - cmd_reg.hx;
    assign dy  = (cmd_reg.hy > cmd_reg.ry) ? cmd_reg.hy - cmd_reg.ry
                                           : cmd_reg.ry - cmd_reg.hy;
    assign sxp = cmd_reg.rx < cmd_reg.hx;
    assign syp = cmd_reg.ry < cmd_reg.hy;
    assign nx  = cx_reg + EW'(ox_reg);
    assign ny  = cy_reg + EW'(oy_reg);
    assign tdx = (nx > rxs) ? nx - rxs : rxs - nx;
    assign tdy = (ny > rys) ? ny - rys : rys - ny;

    function automatic logic on_grid(input logic signed [EW-1:0] x,
                                     input logic signed [EW-1:0] y);
        on_grid = (x >= 0) && (x < EW'(ogru_pkg::GRID_SIZE))
               && (y >= 0) && (y < EW'(ogru_pkg::GRID_SIZE));
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic signed [EW-1:0] x,
                                              input logic signed [EW-1:0] y);
        addr_of = {y[CW-1:0], x[CW-1:0]};
    endfunction

    logic           core_end, bl_end, row_skip, col_skip;
    logic signed [EW:0] e2c, e2b;
    logic [16:0]    cnt_inc;

    assign core_end = (cx_reg == hxs) && (cy_reg == hys);
    assign bl_end   = (bx_reg == nx) && (by_reg == ny);
    assign row_skip = over ? (ny <= hys) : (ny >= hys);
    assign col_skip = right ? (nx >= hxs) : (nx <= hxs);
    assign e2c = {ce_reg, 1'b0};
    assign e2b = {be_reg, 1'b0};
    assign cnt_inc = cnt_reg + 17'd1;

    assign pop  = (state_reg == S_IDLE) && !empty;
    assign idle = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        cnt_next = cnt_reg;
        st_next = st_reg;
        cs_next = cs_reg;
        ch_next = ch_reg;
        cx_next = cx_reg; cy_next = cy_reg; ce_next = ce_reg;
        ox_next = ox_reg; oy_next = oy_reg;
        bx_next = bx_reg; by_next = by_reg; be_next = be_reg;
        bdx_next = bdx_reg; bdy_next = bdy_reg;
        bsx_next = bsx_reg; bsy_next = bsy_reg;
        raddr = addr_of(hxs, hys);
        waddr = clr_reg[AW-1:0];
        occ_we = 1'b0; hit_we = 1'b0;
        occ_wd = ogru_pkg::ST_UNKNOWN; hit_wd = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                occ_we = 1'b1; hit_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(ogru_pkg::DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cnt_next = '0;
                st_next = ogru_pkg::RES_NONE;
                cs_next = ogru_pkg::ST_UNKNOWN;
                ch_next = '0;
                if (!empty)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = cmd_reg.in_grid ? S_UPD : S_OUT;
            end
            S_UPD:
            begin
                waddr = addr_of(hxs, hys);
                if (cmd_reg.is_read)
                begin
                    cs_next = occ_q;
                    ch_next = hit_q;
                    state_next = S_OUT;
                end
                else
                begin
                    hit_wd = (hit_q == 8'hFF) ? hit_q : hit_q + 8'd1;
                    hit_we = 1'b1;
                    ch_next = hit_wd;
                    cs_next = occ_q;
                    state_next = S_OUT;
                    if (hit_wd > threshold)
                    begin
                        if (occ_q != ogru_pkg::ST_OCC)
                        begin
                            occ_we = 1'b1;
                            occ_wd = ogru_pkg::ST_OCC;
                            cs_next = ogru_pkg::ST_OCC;
                            st_next = ogru_pkg::RES_NEW_OCC;
                            if (cmd_reg.rover_in)
                            begin
                                state_next = S_CSTART;
                            end
                        end
                        else
                        begin
                            st_next = ogru_pkg::RES_OLD_OCC;
                        end
                    end
                    else
                    begin
                        st_next = ogru_pkg::RES_COUNTED;
                    end
                end
            end
            S_CSTART:
            begin
                cx_next = rxs; cy_next = rys;
                ce_next = EW'(dx) - EW'(dy);
                state_next = S_CRD;
            end
            S_CRD:
            begin
                raddr = addr_of(cx_reg, cy_reg);
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                waddr = addr_of(cx_reg, cy_reg);
                if (occ_q == ogru_pkg::ST_UNKNOWN)
                begin
                    occ_we = 1'b1;
                    occ_wd = ogru_pkg::ST_FREE;
                    cnt_next = cnt_inc;
                end
                if (core_end)
                begin
                    state_next = S_NSTART;
                end
                else
                begin
                    if (e2c > -$signed((EW+1)'(dy)))
                    begin
                        ce_next = ce_next - EW'(dy);
                        cx_next = sxp ? cx_reg + 1'b1 : cx_reg - 1'b1;
                    end
                    if (e2c < $signed((EW+1)'(dx)))
                    begin
                        ce_next = ce_next + EW'(dx);
                        cy_next = syp ? cy_reg + 1'b1 : cy_reg - 1'b1;
                    end
                    state_next = S_CRD;
                end
            end
            S_NSTART:
            begin
                cx_next = rxs; cy_next = rys;
                ce_next = EW'(dx) - EW'(dy);
                ox_next = -4'(r); oy_next = -4'(r);
                state_next = S_NCHK;
            end
            S_NCHK:
            begin
                raddr = addr_of(nx, ny);
                if (row_skip || col_skip || !on_grid(nx, ny))
                begin
                    state_next = S_NNEXT;
                end
                else
                begin
                    state_next = S_NRD;
                end
            end
            S_NRD:
            begin
                state_next = (occ_q == ogru_pkg::ST_UNKNOWN) ? S_BSTART : S_NNEXT;
            end
            S_BSTART:
            begin
                bx_next = rxs; by_next = rys;
                bdx_next = tdx; bdy_next = tdy;
                bsx_next = rxs < nx; bsy_next = rys < ny;
                be_next = tdx - tdy;
                state_next = S_BRD;
            end
            S_BRD:
            begin
                raddr = addr_of(bx_reg, by_reg);
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (on_grid(bx_reg, by_reg) && occ_q == ogru_pkg::ST_OCC)
                begin
                    state_next = S_NNEXT;
                end
                else if (bl_end)
                begin
                    waddr = addr_of(nx, ny);
                    occ_we = 1'b1;
                    occ_wd = ogru_pkg::ST_FREE;
                    cnt_next = cnt_inc;
                    state_next = S_NNEXT;
                end
                else
                begin
                    if (e2b > -(EW+1)'(bdy_reg))
                    begin
                        be_next = be_next - bdy_reg;
                        bx_next = bsx_reg ? bx_reg + 1'b1 : bx_reg - 1'b1;
                    end
                    if (e2b < (EW+1)'(bdx_reg))
                    begin
                        be_next = be_next + bdx_reg;
                        by_next = bsy_reg ? by_reg + 1'b1 : by_reg - 1'b1;
                    end
                    state_next = S_BRD;
                end
            end
            S_NNEXT:
            begin
                if (EW'(ox_reg) != r)
                begin
                    ox_next = ox_reg + 4'sd1;
                    state_next = S_NCHK;
                end
                else if (EW'(oy_reg) != r)
                begin
                    ox_next = -4'(r);
                    oy_next = oy_reg + 4'sd1;
                    state_next = S_NCHK;
                end
                else if (core_end)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    ox_next = -4'(r);
                    oy_next = -4'(r);
                    if (e2c > -$signed((EW+1)'(dy)))
                    begin
                        ce_next = ce_next - EW'(dy);
                        cx_next = sxp ? cx_reg + 1'b1 : cx_reg - 1'b1;
                    end
                    if (e2c < $signed((EW+1)'(dx)))
                    begin
                        ce_next = ce_next + EW'(dx);
                        cy_next = syp ? cy_reg + 1'b1 : cy_reg - 1'b1;
                    end
                    state_next = S_NCHK;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        cnt_reg <= cnt_next;
        st_reg <= st_next; cs_reg <= cs_next; ch_reg <= ch_next;
        cx_reg <= cx_next; cy_reg <= cy_next; ce_reg <= ce_next;
        ox_reg <= ox_next; oy_reg <= oy_next;
        bx_reg <= bx_next; by_reg <= by_next; be_reg <= be_next;
        bdx_reg <= bdx_next; bdy_reg <= bdy_next;
        bsx_reg <= bsx_next; bsy_reg <= bsy_next;
    end

    assign done        = (state_reg == S_OUT);
    assign status      = st_reg;
    assign freed_cells = cnt_reg[16] ? 16'hFFFF : cnt_reg[15:0];
    assign cell_state  = cs_reg;
    assign cell_hits   = ch_reg;

    `OGRU_ASSERT(a_onehot_state, $onehot(state_reg), "state not one-hot")
    `OGRU_ASSERT(a_out_one_cycle, done |=> !done, "result held more than one cycle")
    `OGRU_ASSERT(a_pop_only_idle, pop |-> idle, "pop outside idle")

endmodule

>>> hdl/occupancy_grid_ray_update_core.sv
// insert: the hit cell is counted and updated before the result strobe; off the grid it is not
// a new obstacle with the rover on the grid adds a walk along the ray cells, and per
// neighbour a check, with a walk of the line-of-sight cells when the neighbour is unknown
// read: one item at a time, the next
// accepted after the strobe; results strobe for one cycle in done, no stall
// after reset the grid is cleared, one cell a cycle, with busy high
module occupancy_grid_ray_update_core
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    opcode,
    input  logic signed [23:0]      hit_x,
    input  logic signed [23:0]      hit_y,
    input  logic signed [23:0]      rover_x,
    input  logic signed [23:0]      rover_y,
    input  logic [7:0]              read_col,
    input  logic [7:0]              read_row,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    output logic                    done,
    output logic [1:0]              status,
    output logic [15:0]             freed_cells,
    output logic [1:0]              cell_state,
    output logic [7:0]              cell_hits
);

    logic [7:0]         thr_reg;
    logic [15:0]        scale_reg;
    logic [1:0]         hw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= 8'd3;
            scale_reg <= 16'd256;
            hw_reg    <= 2'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ogru_pkg::REG_THRESHOLD: thr_reg <= cfg_data[7:0];
                ogru_pkg::REG_SCALE:     scale_reg <= cfg_data;
                ogru_pkg::REG_HALFWIDTH: hw_reg <= cfg_data[1:0];
                default:                 thr_reg <= thr_reg;
            endcase
        end
    end

    logic               q_full, q_empty, push, pop, f_busy, b_idle;
    ogru_pkg::cmd_t     push_cmd, head;

    ogru_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start && !busy),
        .opcode   (opcode),
        .hit_x    (hit_x),
        .hit_y    (hit_y),
        .rover_x  (rover_x),
        .rover_y  (rover_y),
        .read_col (read_col),
        .read_row (read_row),
        .scale    (scale_reg),
        .q_full   (q_full),
        .busy     (f_busy),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ogru_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    ogru_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (q_empty),
        .head        (head),
        .threshold   (thr_reg),
        .halfwidth   (hw_reg),
        .pop         (pop),
        .idle        (b_idle),
        .done        (done),
        .status      (status),
        .freed_cells (freed_cells),
        .cell_state  (cell_state),
        .cell_hits   (cell_hits)
    );

    // one item in flight at a time
    assign busy = f_busy || !q_empty || !b_idle;

endmodule

>>> tb/tb_occupancy_grid_ray_update_core.sv
module tb_occupancy_grid_ray_update_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 64'd4_000_000_000;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] freed;
        logic [1:0]  state;
        logic [7:0]  hits;
    } grid_result_t;

    typedef struct {
        logic        op;
        logic [23:0] hx;
        logic [23:0] hy;
        logic [23:0] rx;
        logic [23:0] ry;
        logic [7:0]  col;
        logic [7:0]  row;
    } grid_cmd_t;

    class grid_scoreboard;
        logic [1:0]   occ [ogru_pkg::DEPTH];
        logic [7:0]   hit_cnt [ogru_pkg::DEPTH];
        int unsigned  threshold;
        int unsigned  scale;
        int unsigned  halfwidth;
        grid_result_t pending [$];
        int           errors;

        function new();
            foreach (occ[i])
            begin
                occ[i] = ogru_pkg::ST_UNKNOWN;
                hit_cnt[i] = 8'd0;
            end
            threshold = 3;
            scale = 256;
            halfwidth = 2;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == ogru_pkg::REG_THRESHOLD)
                threshold = val[7:0];
            else if (idx == ogru_pkg::REG_SCALE)
                scale = val;
            else if (idx == ogru_pkg::REG_HALFWIDTH)
                halfwidth = val[1:0];
        endfunction

        // world Q16.8 to cell index, truncating toward zero
        function int cell_of(logic [23:0] raw);
            longint unsigned mag;
            longint unsigned q;
            mag = raw[23] ? (64'h1000000 - 64'(raw)) : 64'(raw);
            q = (mag * scale) >> 16;
            return (raw[23] ? -int'(q) : int'(q)) + ogru_pkg::GRID_SIZE / 2;
        endfunction

        function bit on_grid(int x, int y);
            return x >= 0 && x < ogru_pkg::GRID_SIZE && y >= 0 && y < ogru_pkg::GRID_SIZE;
        endfunction

        function bit line_blocked(int x0, int y0, int x1, int y1);
            int x, y, dx, dy, sx, sy, err, e2;
            x = x0;
            y = y0;
            dx = x1 > x0 ? x1 - x0 : x0 - x1;
            dy = y1 > y0 ? y1 - y0 : y0 - y1;
            sx = x0 < x1 ? 1 : -1;
            sy = y0 < y1 ? 1 : -1;
            err = dx - dy;
            while (1)
            begin
                if (on_grid(x, y) && occ[y * ogru_pkg::GRID_SIZE + x] == ogru_pkg::ST_OCC)
                    return 1;
                if (x == x1 && y == y1)
                    break;
                e2 = 2 * err;
                if (e2 > -dy)
                begin
                    err -= dy;
                    x += sx;
                end
                if (e2 < dx)
                begin
                    err += dx;
                    y += sy;
                end
            end
            return 0;
        endfunction

        function int unsigned sweep_ray(int rx, int ry, int hx, int hy);
            int x, y, dx, dy, sx, sy, err, e2, nx, ny, r, pass;
            int unsigned cnt;
            bit over, right;
            cnt = 0;
            r = halfwidth;
            over = hy < ry;
            right = hx > rx;
            dx = hx > rx ? hx - rx : rx - hx;
            dy = hy > ry ? hy - ry : ry - hy;
            sx = rx < hx ? 1 : -1;
            sy = ry < hy ? 1 : -1;
            // core line first, then the thickening pass
            for (pass = 0; pass < 2; pass++)
            begin
                x = rx;
                y = ry;
                err = dx - dy;
                while (1)
                begin
                    if (pass == 0)
                    begin
                        if (occ[y * ogru_pkg::GRID_SIZE + x] == ogru_pkg::ST_UNKNOWN)
                        begin
                            occ[y * ogru_pkg::GRID_SIZE + x] = ogru_pkg::ST_FREE;
                            cnt++;
                        end
                    end
                    else
                    begin
                        for (ny = y - r; ny <= y + r; ny++)
                        begin
                            if (over ? (ny <= hy) : (ny >= hy))
                                continue;
                            for (nx = x - r; nx <= x + r; nx++)
                            begin
                                if (right ? (nx >= hx) : (nx <= hx))
                                    continue;
                                if (!on_grid(nx, ny))
                                    continue;
                                if (occ[ny * ogru_pkg::GRID_SIZE + nx] != ogru_pkg::ST_UNKNOWN)
                                    continue;
                                if (line_blocked(rx, ry, nx, ny))
                                    continue;
                                occ[ny * ogru_pkg::GRID_SIZE + nx] = ogru_pkg::ST_FREE;
                                cnt++;
                            end
                        end
                    end
                    if (x == hx && y == hy)
                        break;
                    e2 = 2 * err;
                    if (e2 > -dy)
                    begin
                        err -= dy;
                        x += sx;
                    end
                    if (e2 < dx)
                    begin
                        err += dx;
                        y += sy;
                    end
                end
            end
            return cnt;
        endfunction

        function void note_beat(grid_cmd_t c);
            grid_result_t res;
            int hx, hy, rx, ry, idx;
            int unsigned n;
            res = '{ogru_pkg::RES_NONE, 16'd0, ogru_pkg::ST_UNKNOWN, 8'd0};
            if (c.op == ogru_pkg::OP_READ)
            begin
                idx = int'(c.row) * ogru_pkg::GRID_SIZE + int'(c.col);
                res.state = occ[idx];
                res.hits = hit_cnt[idx];
            end
            else
            begin
                hx = cell_of(c.hx);
                hy = cell_of(c.hy);
                if (on_grid(hx, hy))
                begin
                    idx = hy * ogru_pkg::GRID_SIZE + hx;
                    if (hit_cnt[idx] != 8'hff)
                        hit_cnt[idx]++;
                    if (hit_cnt[idx] > threshold)
                    begin
                        if (occ[idx] != ogru_pkg::ST_OCC)
                        begin
                            occ[idx] = ogru_pkg::ST_OCC;
                            res.status = ogru_pkg::RES_NEW_OCC;
                            rx = cell_of(c.rx);
                            ry = cell_of(c.ry);
                            n = on_grid(rx, ry) ? sweep_ray(rx, ry, hx, hy) : 0;
                            res.freed = n > 65535 ? 16'hffff : n[15:0];
                        end
                        else
                            res.status = ogru_pkg::RES_OLD_OCC;
                    end
                    else
                        res.status = ogru_pkg::RES_COUNTED;
                    res.state = occ[idx];
                    res.hits = hit_cnt[idx];
                end
            end
            pending.insert(pending.size(), res);
        endfunction

        function void check_beat(grid_result_t got);
            grid_result_t exp_res;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (got.status !== exp_res.status)
            begin
                $error("status expected %0d actual %0d", exp_res.status, got.status);
                errors++;
            end
            if (got.freed !== exp_res.freed)
            begin
                $error("freed_cells expected %0d actual %0d", exp_res.freed, got.freed);
                errors++;
            end
            if (got.state !== exp_res.state)
            begin
                $error("cell_state expected %0d actual %0d", exp_res.state, got.state);
                errors++;
            end
            if (got.hits !== exp_res.hits)
            begin
                $error("cell_hits expected %0d actual %0d", exp_res.hits, got.hits);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               opcode;
    logic signed [23:0] hit_x;
    logic signed [23:0] hit_y;
    logic signed [23:0] rover_x;
    logic signed [23:0] rover_y;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               done;
    logic [1:0]         status;
    logic [15:0]        freed_cells;
    logic [1:0]         cell_state;
    logic [7:0]         cell_hits;

    grid_scoreboard grid_sb;
    grid_cmd_t      cmd_q [$];
    longint         cycle_cnt;

    occupancy_grid_ray_update_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .hit_x(hit_x),
        .hit_y(hit_y),
        .rover_x(rover_x),
        .rover_y(rover_y),
        .read_col(read_col),
        .read_row(read_row),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .done(done),
        .status(status),
        .freed_cells(freed_cells),
        .cell_state(cell_state),
        .cell_hits(cell_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            grid_sb.check_beat('{status, freed_cells, cell_state, cell_hits});
    end

    // world coordinate about cells units from the origin, fraction random
    function automatic logic [23:0] world(int cells);
        int frac;
        frac = $urandom_range(0, 255);
        return cells >= 0 ? 24'(cells * 256 + frac) : 24'(cells * 256 - frac);
    endfunction

    function automatic grid_cmd_t insert_cmd(int hx, int hy, int rx, int ry);
        return '{ogru_pkg::OP_INSERT, world(hx), world(hy), world(rx), world(ry), 8'd0, 8'd0};
    endfunction

    function automatic grid_cmd_t read_cmd(int col, int row);
        return '{ogru_pkg::OP_READ, 24'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom), 8'(col), 8'(row)};
    endfunction

    function automatic grid_cmd_t random_cmd();
        int pick, hx, hy;
        grid_cmd_t c;
        pick = $urandom_range(0, 99);
        hx = $signed($urandom_range(0, 16)) - 8;
        hy = $signed($urandom_range(0, 16)) - 8;
        if (pick < 70)
            c = insert_cmd(hx, hy, hx + $signed($urandom_range(0, 24)) - 12,
                           hy + $signed($urandom_range(0, 24)) - 12);
        else if (pick < 80)
            c = read_cmd(128 + $signed($urandom_range(0, 32)) - 16,
                         128 + $signed($urandom_range(0, 32)) - 16);
        else if (pick < 90)
            c = read_cmd($urandom_range(0, 255), $urandom_range(0, 255));
        else
        begin
            c = read_cmd(0, 0);
            c.op = ogru_pkg::OP_INSERT;
            c.col = 8'($urandom);
            c.row = 8'($urandom);
        end
        return c;
    endfunction

    task automatic add_cmd(grid_cmd_t c);
        cmd_q.insert(cmd_q.size(), c);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        grid_sb.set_reg(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_cmds();
        int gaps [$];
        int i;
        for (i = 0; i <= cmd_q.size(); i++)
            gaps.insert(gaps.size(), $urandom_range(0, 1) ? 0 : $urandom_range(0, 7));
        repeat (gaps[0]) @(posedge clk);
        for (i = 0; i < cmd_q.size(); i++)
        begin
            start <= 1'b1;
            opcode <= cmd_q[i].op;
            hit_x <= cmd_q[i].hx;
            hit_y <= cmd_q[i].hy;
            rover_x <= cmd_q[i].rx;
            rover_y <= cmd_q[i].ry;
            read_col <= cmd_q[i].col;
            read_row <= cmd_q[i].row;
            do
                @(posedge clk);
            while (busy);
            grid_sb.note_beat(cmd_q[i]);
            if (i == cmd_q.size() - 1 || gaps[i + 1] > 0)
                start <= 1'b0;
            repeat (gaps[i + 1]) @(posedge clk);
        end
        cmd_q.delete();
    endtask

    task automatic drain();
        while (grid_sb.pending.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    initial
    begin
        int p, k;
        int unsigned thr [5] = '{0, 1, 254, 2, 0};
        int unsigned scl [5] = '{256, 128, 65535, 512, 1};
        int unsigned hw [5] = '{3, 0, 1, 3, 2};
        grid_sb = new();
        cycle_cnt = 0;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = ogru_pkg::OP_INSERT;
        hit_x = '0;
        hit_y = '0;
        rover_x = '0;
        rover_y = '0;
        read_col = '0;
        read_row = '0;
        cfg_we = 1'b0;
        cfg_index = ogru_pkg::REG_THRESHOLD;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // directed, at reset settings
        add_cmd('{ogru_pkg::OP_INSERT, 24'h800000, 24'h7fffff, 24'h0, 24'h0, 8'd0, 8'd0});
        add_cmd('{ogru_pkg::OP_INSERT, 24'h7fffff, 24'h800000, 24'hffffff, 24'h0,
                  8'hff, 8'hff});
        add_cmd(read_cmd(0, 0));
        add_cmd(read_cmd(255, 255));
        for (k = 0; k < 4; k++)
            add_cmd(insert_cmd(5, 3, -4, -2));
        add_cmd(insert_cmd(5, 3, -4, -2));
        add_cmd(read_cmd(128, 128));
        add_cmd(read_cmd(129, 129));
        // negative coordinates truncate toward zero
        for (k = 0; k < 4; k++)
            add_cmd('{ogru_pkg::OP_INSERT, 24'hffff80, 24'hffff01, 24'h000500, 24'hfff900,
                      8'd0, 8'd0});
        add_cmd(read_cmd(128, 128));
        // rover off the grid, then hits near the grid edges
        for (k = 0; k < 4; k++)
            add_cmd(insert_cmd(-6, 7, 200, 0));
        add_cmd(insert_cmd(-127, -128, 0, 0));
        add_cmd(insert_cmd(127, 128, 0, 0));
        add_cmd(read_cmd(122, 135));
        run_cmds();
        repeat (16)
            add_cmd(random_cmd());
        run_cmds();
        drain();

        for (p = 0; p < 5; p++)
        begin
            write_reg(ogru_pkg::REG_THRESHOLD, 16'(thr[p]));
            write_reg(ogru_pkg::REG_SCALE, 16'(scl[p]));
            write_reg(ogru_pkg::REG_HALFWIDTH, 16'(hw[p]));
            repeat (16)
                add_cmd(random_cmd());
            run_cmds();
            drain();
        end

        if (grid_sb.errors == 0 && grid_sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
